[rtl/tut_pkg.sv]
// Shared types and constants for the timed UART transceiver.
// No dependencies; used by tut_tx, tut_rx and timed_uart_transceiver_core.
`default_nettype none

package tut_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_TIME = 1'd1;

    // Register widths and reset values
    localparam int BIT_TIME_W  = 16;
    localparam int HALF_TIME_W = 15;

    localparam logic [BIT_TIME_W-1:0]  BIT_TIME_RST  = 16'd138;
    localparam logic [HALF_TIME_W-1:0] HALF_TIME_RST = 15'd69;

    // Frame geometry
    localparam int FRAME_CNT_W = 4;
    localparam logic [FRAME_CNT_W-1:0] TX_FRAME_BITS = 4'd10;
    localparam logic [FRAME_CNT_W-1:0] RX_SAMPLES    = 4'd9;

    // Item widths on the stream ports
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Transmitter status after a tick
    typedef struct packed {
        logic line;
        logic busy;
    } t_tx_stat;

    // Receiver result after a tick
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_rx_res;

endpackage

`default_nettype wire

[rtl/timed_uart_transceiver_core.sv]
// Tick-driven 8N1 UART transceiver: each accepted item is one timer tick.
// An item's result is registered and presented in the cycle after it is accepted.
// One item per cycle while results are taken; a new item enters as a result drains.
// Reset (synchronous, active low) restores registers to 138/69, idles both
// directions with the transmit line at mark, and empties the output register.
// Depends on tut_pkg, tut_tx and tut_rx.
`default_nettype none

module timed_uart_transceiver_core #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration writes
    input  wire                                i_cfg_we,
    input  wire  [tut_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [tut_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // tick items in
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] rx_line, [1] tx_start, [9:2] tx_byte, [15:10] zero
    input  wire  [tut_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // result items out
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [0] tx_line, [1] tx_busy, [2] rx_valid, [10:3] rx_byte, [15:11] zero
    output logic [tut_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int SUM_W = ((TIMER_WIDTH > tut_pkg::HALF_TIME_W) ?
                            TIMER_WIDTH : tut_pkg::HALF_TIME_W) + 1;

    logic [tut_pkg::BIT_TIME_W-1:0]  r_bit_time;
    logic [tut_pkg::HALF_TIME_W-1:0] r_half_time;
    logic                            r_out_valid;
    logic [tut_pkg::M_TDATA_W-1:0]   r_out_data;

    logic                            w_accept;
    logic [TIMER_WIDTH-1:0]          w_period;
    logic [SUM_W-1:0]                w_sum;
    logic [TIMER_WIDTH:0]            w_first_wait;
    tut_pkg::t_tx_stat               w_tx_stat;
    tut_pkg::t_rx_res                w_rx_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_time  <= tut_pkg::BIT_TIME_RST;
            r_half_time <= tut_pkg::HALF_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tut_pkg::REG_BIT_TIME:      r_bit_time  <= i_cfg_data;
                tut_pkg::REG_HALF_BIT_TIME: r_half_time <= i_cfg_data[tut_pkg::HALF_TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Timer loads: bit period fitted to the timer, first receive wait to mid-bit
    assign w_period     = TIMER_WIDTH'(r_bit_time);
    assign w_sum        = SUM_W'(w_period) + SUM_W'(r_half_time);
    assign w_first_wait = w_sum[TIMER_WIDTH:0];

    // Handshake: take an item when the output slot is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    tut_tx #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (w_accept),
        .i_tx_start (s_axis_tdata[1]),
        .i_tx_byte  (s_axis_tdata[9:2]),
        .i_period   (w_period),
        .o_stat     (w_tx_stat)
    );

    tut_rx #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_accept),
        .i_rx_line    (s_axis_tdata[0]),
        .i_period     (w_period),
        .i_first_wait (w_first_wait),
        .o_res        (w_rx_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {5'd0, w_rx_res.data, w_rx_res.valid,
                           w_tx_stat.busy, w_tx_stat.line};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[rtl/tut_tx.sv]
// 8N1 transmitter: frame shifter with a bit-period countdown, advanced once per tick.
// Depends on tut_pkg.
`default_nettype none

module tut_tx #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_tick,
    input  wire                   i_tx_start,
    input  wire  [7:0]            i_tx_byte,
    input  wire  [TIMER_WIDTH-1:0] i_period,
    output tut_pkg::t_tx_stat     o_stat
);

    logic [9:0]                        r_frame,  n_frame;
    logic [tut_pkg::FRAME_CNT_W-1:0]   r_bits,   n_bits;
    logic [TIMER_WIDTH-1:0]            r_cnt,    n_cnt;
    logic                              r_active, n_active;
    logic                              r_level,  n_level;

    // Next state for one tick
    always_comb begin
        n_frame  = r_frame;
        n_bits   = r_bits;
        n_cnt    = r_cnt;
        n_active = r_active;
        n_level  = r_level;
        if (r_active) begin
            if (r_cnt <= TIMER_WIDTH'(1)) begin
                n_cnt = i_period;
                if (r_bits == '0) begin
                    n_active = 1'b0;
                    n_bits   = tut_pkg::TX_FRAME_BITS;
                end else begin
                    n_level = r_frame[0];
                    n_frame = {1'b0, r_frame[9:1]};
                    n_bits  = r_bits - 1'b1;
                end
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end else if (i_tx_start) begin
            // stop bit, data LSB first, start bit
            n_frame  = {1'b1, i_tx_byte, 1'b0};
            n_bits   = tut_pkg::TX_FRAME_BITS;
            n_cnt    = i_period;
            n_active = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame  <= '0;
            r_bits   <= tut_pkg::TX_FRAME_BITS;
            r_cnt    <= '0;
            r_active <= 1'b0;
            r_level  <= 1'b1;
        end else if (i_tick) begin
            r_frame  <= n_frame;
            r_bits   <= n_bits;
            r_cnt    <= n_cnt;
            r_active <= n_active;
            r_level  <= n_level;
        end
    end

    // Status as it stands after this tick
    assign o_stat.line = n_level;
    assign o_stat.busy = n_active;

endmodule

`default_nettype wire

[rtl/tut_rx.sv]
// 8N1 receiver: start-edge hunt, mid-bit sample countdown and nine-sample shifter.
// Depends on tut_pkg.
`default_nettype none

module tut_rx #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_tick,
    input  wire                    i_rx_line,
    input  wire  [TIMER_WIDTH-1:0] i_period,
    input  wire  [TIMER_WIDTH:0]   i_first_wait,
    output tut_pkg::t_rx_res       o_res
);

    logic [8:0]                       r_frame,   n_frame;
    logic [tut_pkg::FRAME_CNT_W-1:0]  r_bits,    n_bits;
    logic [TIMER_WIDTH:0]             r_cnt,     n_cnt;
    logic                             r_hunting, n_hunting;
    logic                             r_prev;
    logic [8:0]                       w_shift;

    assign w_shift = {i_rx_line, r_frame[8:1]};

    // Next state for one tick
    always_comb begin
        n_frame     = r_frame;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        n_hunting   = r_hunting;
        o_res.valid = 1'b0;
        o_res.data  = '0;
        if (r_hunting) begin
            // falling edge marks the start bit
            if (r_prev && !i_rx_line) begin
                n_cnt     = i_first_wait;
                n_hunting = 1'b0;
            end
        end else if (r_cnt <= (TIMER_WIDTH+1)'(1)) begin
            n_cnt = (TIMER_WIDTH+1)'(i_period);
            if (r_bits <= tut_pkg::FRAME_CNT_W'(1)) begin
                // stop sample taken; byte is the low eight bits
                o_res.valid = 1'b1;
                o_res.data  = w_shift[7:0];
                n_frame     = '0;
                n_bits      = tut_pkg::RX_SAMPLES;
                n_hunting   = 1'b1;
            end else begin
                n_frame = w_shift;
                n_bits  = r_bits - 1'b1;
            end
        end else begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame   <= '0;
            r_bits    <= tut_pkg::RX_SAMPLES;
            r_cnt     <= '0;
            r_hunting <= 1'b1;
            r_prev    <= 1'b1;
        end else if (i_tick) begin
            r_frame   <= n_frame;
            r_bits    <= n_bits;
            r_cnt     <= n_cnt;
            r_hunting <= n_hunting;
            r_prev    <= i_rx_line;
        end
    end

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for timed_uart_transceiver_core: queued tick items, a cycle model
// of the 8N1 transmitter and receiver, and a field-by-field check of every result item.
// Depends on tut_pkg and the core RTL.

module testbench;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 4;

    // Input item layout, lowest bit first: rx_line, tx_start, tx_byte
    typedef struct packed {
        logic [5:0] pad;
        logic [7:0] tx_byte;
        logic       tx_start;
        logic       rx_line;
    } t_tick;

    // Result item layout, lowest bit first: tx_line, tx_busy, rx_valid, rx_byte
    typedef struct packed {
        logic [4:0] pad;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       tx_busy;
        logic       tx_line;
    } t_line_stat;

    typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} t_pace;

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [tut_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tut_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_valid   = 1'b0;
    logic [tut_pkg::S_TDATA_W-1:0]  s_data    = '0;
    wire                            s_axis_tready;
    wire                            m_axis_tvalid;
    logic                           m_ready   = 1'b0;
    wire  [tut_pkg::M_TDATA_W-1:0]  m_axis_tdata;

    timed_uart_transceiver_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_data),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_axis_tdata)
    );

    t_tick      tick_queue[$];
    t_line_stat status_due[$];
    t_pace      pace_mode = PACE_FULL;
    bit         hold_req  = 1'b0;
    bit         in_taken  = 1'b0;
    int         errors    = 0;
    int         result_num = 0;

    // Model state: timing registers
    logic [tut_pkg::BIT_TIME_W-1:0]  bit_period;
    logic [tut_pkg::HALF_TIME_W-1:0] half_period;
    // transmitter
    logic [9:0]                      tx_shift;
    logic [tut_pkg::FRAME_CNT_W-1:0] tx_left;
    logic [15:0]                     tx_timer;
    logic                            tx_on;
    logic                            tx_lvl;
    // receiver
    logic [8:0]                      rx_shift;
    logic [tut_pkg::FRAME_CNT_W-1:0] rx_left;
    logic [16:0]                     rx_timer;
    logic                            rx_hunt;
    logic                            rx_prev;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic uart_model_reset();
        bit_period  = tut_pkg::BIT_TIME_RST;
        half_period = tut_pkg::HALF_TIME_RST;
        tx_shift    = '0;
        tx_left     = tut_pkg::TX_FRAME_BITS;
        tx_timer    = '0;
        tx_on       = 1'b0;
        tx_lvl      = 1'b1;
        rx_shift    = '0;
        rx_left     = tut_pkg::RX_SAMPLES;
        rx_timer    = '0;
        rx_hunt     = 1'b1;
        rx_prev     = 1'b1;
    endtask

    // One timer tick of both directions; returns the line status after it
    function automatic t_line_stat uart_tick(input t_tick t);
        t_line_stat r;
        r = '0;
        // transmitter: a request is taken only when idle at the start of the tick
        if (tx_on) begin
            if (tx_timer <= 16'd1) begin
                tx_timer = bit_period;
                if (tx_left == '0) begin
                    tx_on   = 1'b0;
                    tx_left = tut_pkg::TX_FRAME_BITS;
                end else begin
                    tx_lvl   = tx_shift[0];
                    tx_shift = tx_shift >> 1;
                    tx_left  = tx_left - 1'b1;
                end
            end else begin
                tx_timer = tx_timer - 1'b1;
            end
        end else if (t.tx_start) begin
            tx_shift = {1'b1, t.tx_byte, 1'b0};
            tx_left  = tut_pkg::TX_FRAME_BITS;
            tx_timer = bit_period;
            tx_on    = 1'b1;
        end
        // receiver: falling edge, then mid-bit samples
        if (rx_hunt) begin
            if (rx_prev && !t.rx_line) begin
                rx_timer = {1'b0, bit_period} + {2'b00, half_period};
                rx_hunt  = 1'b0;
            end
        end else if (rx_timer <= 17'd1) begin
            rx_timer = {1'b0, bit_period};
            rx_shift = {t.rx_line, rx_shift[8:1]};
            if (rx_left <= 4'd1) begin
                r.rx_valid = 1'b1;
                r.rx_byte  = rx_shift[7:0];
                rx_shift   = '0;
                rx_left    = tut_pkg::RX_SAMPLES;
                rx_hunt    = 1'b1;
            end else begin
                rx_left = rx_left - 1'b1;
            end
        end else begin
            rx_timer = rx_timer - 1'b1;
        end
        rx_prev   = t.rx_line;
        r.tx_line = tx_lvl;
        r.tx_busy = tx_on;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", result_num, what, got, want);
        errors++;
    endtask

    function automatic bit sender_rests();
        if (pace_mode == PACE_SEND_GAPS) return $urandom_range(0, 99) < 72;
        if (pace_mode == PACE_BOTH) return $urandom_range(0, 99) < 29;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        if (pace_mode == PACE_RECV_STALLS) return $urandom_range(0, 99) < 72;
        if (pace_mode == PACE_BOTH) return $urandom_range(0, 99) < 29;
        return 1'b0;
    endfunction

    // Driver: holds an item until taken, then offers the next one or idles
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_valid || in_taken)) begin
            if (tick_queue.size() != 0 && !sender_rests()) begin
                s_data  <= tick_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver side: random stalls plus one long hold-off when requested
    int  hold_left = 0;
    bit  hold_seen = 1'b0;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !receiver_stalls();
        end
    end

    // Monitor: config writes, accepted ticks and result checks
    always @(posedge i_clk) begin
        t_line_stat got;
        t_line_stat want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
            uart_model_reset();
        end else begin
            in_taken = s_valid && s_axis_tready;
            if (cfg_we) begin
                if (cfg_index == tut_pkg::REG_BIT_TIME)
                    bit_period = cfg_data;
                else if (cfg_index == tut_pkg::REG_HALF_BIT_TIME)
                    half_period = cfg_data[tut_pkg::HALF_TIME_W-1:0];
            end
            // check before predicting, so a stray result never meets a fresh expectation
            if (m_axis_tvalid && m_ready) begin
                got = t_line_stat'(m_axis_tdata);
                if (status_due.size() == 0) begin
                    flag_mismatch("unexpected item", m_axis_tdata, 0);
                end else begin
                    want = status_due.pop_front();
                    if (got.tx_line !== want.tx_line)
                        flag_mismatch("tx_line", got.tx_line, want.tx_line);
                    if (got.tx_busy !== want.tx_busy)
                        flag_mismatch("tx_busy", got.tx_busy, want.tx_busy);
                    if (got.rx_valid !== want.rx_valid)
                        flag_mismatch("rx_valid", got.rx_valid, want.rx_valid);
                    if (got.rx_byte !== want.rx_byte)
                        flag_mismatch("rx_byte", got.rx_byte, want.rx_byte);
                    if (got.pad !== want.pad)
                        flag_mismatch("pad bits", got.pad, want.pad);
                end
                result_num++;
            end
            if (in_taken)
                status_due.push_back(uart_tick(t_tick'(s_data)));
        end
    end

    // Watchdog: cycles with no item moving on either side
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic queue_item(input logic line, input logic start, input logic [7:0] data);
        t_tick t;
        t = '0;
        t.rx_line  = line;
        t.tx_start = start;
        t.tx_byte  = data;
        tick_queue.push_back(t);
    endtask

    task automatic queue_tick(input logic line, input int tx_pct);
        queue_item(line, $urandom_range(0, 99) < tx_pct, 8'($urandom));
    endtask

    // Serial frame on the receive line: start, data LSB first, stop
    task automatic queue_rx_frame(input logic [7:0] data, input logic stop, input int per,
                                  input int tx_pct);
        logic [9:0] bits;
        bits = {stop, data, 1'b0};
        for (int b = 0; b < 10; b++)
            for (int k = 0; k < per; k++)
                queue_tick(bits[b], tx_pct);
    endtask

    // Mostly well-formed frames, some cut-short starts and line noise; only line noise unless framed
    task automatic queue_line_traffic(input int n, input int per, input bit framed);
        int goal;
        int pick;
        goal = tick_queue.size() + n;
        while (tick_queue.size() < goal) begin
            pick = $urandom_range(0, 9);
            if (framed && pick < 7) begin
                queue_rx_frame(8'($urandom), $urandom_range(0, 7) != 0, per, 10);
                repeat ($urandom_range(0, 2 * per)) queue_tick(1'b1, 10);
            end else if (framed && pick == 7) begin
                repeat ($urandom_range(1, per)) queue_tick(1'b0, 10);
                repeat ($urandom_range(1, 3 * per)) queue_tick(1'b1, 10);
            end else begin
                repeat ($urandom_range(1, 8)) queue_tick(1'($urandom_range(0, 1)), 10);
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (tick_queue.size() != 0 || s_valid || status_due.size() != 0);
    endtask

    // Registers change only with nothing in flight
    task automatic start_phase(input logic [tut_pkg::CFG_DATA_W-1:0] bit_val,
                               input logic [tut_pkg::CFG_DATA_W-1:0] half_val,
                               input t_pace pace);
        wait_drained();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= tut_pkg::REG_BIT_TIME;
        cfg_data  <= bit_val;
        @(negedge i_clk);
        cfg_index <= tut_pkg::REG_HALF_BIT_TIME;
        cfg_data  <= half_val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
        #1;
        pace_mode = pace;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // reset timing: a frame starts with the long default bit time,
        // requests while busy are dropped; later writes land mid-frame
        queue_item(1'b1, 1'b1, 8'hFF);
        queue_item(1'b1, 1'b1, 8'h00);
        queue_item(1'b1, 1'b0, 8'h3C);
        queue_item(1'b1, 1'b1, 8'hA5);

        // zero bit time behaves like one: all-zero byte, all-ones byte
        // with a framing error, back to back
        start_phase('0, '0, PACE_FULL);
        queue_rx_frame(8'h00, 1'b1, 1, 0);
        queue_rx_frame(8'hFF, 1'b0, 1, 0);
        queue_item(1'b1, 1'b1, 8'h81);
        queue_item(1'b1, 1'b0, 8'h7E);

        start_phase(16'd4, 16'd2, PACE_FULL);
        queue_line_traffic(400, 4, 1'b1);

        start_phase(16'd7, 16'd3, PACE_SEND_GAPS);
        queue_line_traffic(350, 7, 1'b1);

        // long receiver hold-off fills the block and stalls its input
        start_phase(16'd1, 16'd0, PACE_RECV_STALLS);
        hold_req = 1'b1;
        queue_line_traffic(300, 1, 1'b1);

        start_phase(16'd12, 16'd6, PACE_BOTH);
        queue_line_traffic(400, 12, 1'b1);

        // widest settings; bit 15 of the half-bit write is dropped
        start_phase(16'hFFFF, 16'hFFFF, PACE_FULL);
        queue_line_traffic(100, 1, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        #1;
        if (status_due.size() != 0)
            flag_mismatch("results never delivered", status_due.size(), 0);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
